// ----- design/ftgc_pkg.sv -----
// Package for the force/torque gravity compensation block.
// Holds payload structs, codes, fixed widths, reset values and saturation helpers.
// No dependencies.
package ftgc_pkg;

    localparam int V_W        = 32;
    localparam int ROT_W      = 16;
    localparam int ROT_FRAC   = 14;
    localparam int AXES       = 3;
    localparam int LEVER_FRAC = 24;
    localparam int SUM_W      = 48;
    localparam int CNT_W      = 16;
    localparam int MUL_W      = 33;
    localparam int WIDE_W     = 68;

    localparam logic signed [ROT_W-1:0] ROT_ONE = ROT_W'(1 << ROT_FRAC);

    localparam logic [30:0] WEIGHT_RESET = 31'd70439;
    localparam logic [30:0] LEVER_RESET  = 31'd172805;
    localparam logic [15:0] CALIB_RESET  = 16'd1000;

    localparam logic signed [V_W-1:0] DEFAULT_BIAS [2*AXES] = '{
        -32'sd938626, 32'sd81776, -32'sd410157, 32'sd1776, 32'sd50214, 32'sd2353
    };

    typedef enum logic [1:0] {
        CFG_WEIGHT = 2'd0,
        CFG_LEVER  = 2'd1,
        CFG_CALIB  = 2'd2,
        CFG_NONE   = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ACT_ROW0   = 2'd0,
        ACT_ROW1   = 2'd1,
        ACT_ROW2   = 2'd2,
        ACT_SAMPLE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GRAV,
        S_LEV,
        S_VEC,
        S_ROT,
        S_DIV,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]        action;
        logic signed [15:0] row_x;
        logic signed [15:0] row_y;
        logic signed [15:0] row_z;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic signed [31:0] torque_x;
        logic signed [31:0] torque_y;
        logic signed [31:0] torque_z;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] comp_force_x;
        logic signed [31:0] comp_force_y;
        logic signed [31:0] comp_force_z;
        logic signed [31:0] comp_torque_x;
        logic signed [31:0] comp_torque_y;
        logic signed [31:0] comp_torque_z;
    } out_word_t;

    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] dividend;
        logic [CNT_W-1:0]        divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic signed [SUM_W:0] quotient;
    } div_rsp_t;

    function automatic logic signed [V_W-1:0] sat_v(input logic signed [WIDE_W-1:0] x);
        logic signed [V_W-1:0] r;
        if (x[WIDE_W-1:V_W-1] == '0 || x[WIDE_W-1:V_W-1] == '1)
            r = x[V_W-1:0];
        else
            r = x[WIDE_W-1] ? {1'b1, {(V_W-1){1'b0}}} : {1'b0, {(V_W-1){1'b1}}};
        return r;
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [WIDE_W-1:0] x);
        logic signed [SUM_W-1:0] r;
        if (x[WIDE_W-1:SUM_W-1] == '0 || x[WIDE_W-1:SUM_W-1] == '1)
            r = x[SUM_W-1:0];
        else
            r = x[WIDE_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        return r;
    endfunction

endpackage

// ----- design/ft_sensor_gravity_compensation.sv -----
// Gravity compensation for a six-axis force/torque sensor, top level.
// Depends on ftgc_pkg, ftgc_mul and ftgc_div.
//
// The in channel carries one word per item: a rotation row load (action 0 to 2)
// or a wrench sample (action 3). Row loads keep the block ready.
// A sample runs through one shared 33 by 33 multiplier under a sequencer: gravity,
// then lever torque, then the subtraction, then the rotation, after which the
// result word is registered.
// The next item is accepted once that word is in the output register.
// During bias calibration a sample gives no result; the last calibration sample
// also runs six divisions in the shared divider, one after another.
// The cfg channel is always ready and writes weight, lever arm and calibration
// count; the user must write it only while the block is idle; the block does not enforce this.
// Reset restores the identity rotation, the default bias, the register reset
// values and starts a new calibration. A stalled receiver holds the output word
// and the block, having finished the next sample, waits until it is taken.
module ft_sensor_gravity_compensation
    import ftgc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [31:0] cfg_data
);

    state_t state_reg, state_next;

    logic [30:0]      weight_reg;
    logic [30:0]      lever_reg;
    logic [15:0]      calib_reg;
    logic signed [ROT_W-1:0] rot_reg [9];
    logic signed [V_W-1:0]   g_reg [AXES];
    logic signed [V_W-1:0]   lev_reg [2];
    logic signed [V_W-1:0]   v_reg [2*AXES];
    logic signed [V_W-1:0]   bias_reg [2*AXES];
    logic signed [SUM_W-1:0] sum_reg [2*AXES];
    logic signed [V_W-1:0]   res_reg [2*AXES];
    logic signed [V_W-1:0]   out_reg [2*AXES];
    logic [CNT_W-1:0] seen_reg;
    logic             cal_reg;
    logic             cal_mode_reg;
    in_word_t         in_reg;
    logic [2:0]       idx_reg;
    logic             ph_reg;
    logic [1:0]       r_reg;
    logic [1:0]       c_reg;
    logic             h_reg;
    logic signed [V_W+2:0] acc_reg;
    logic             out_valid_reg;

    logic signed [MUL_W-1:0]   ma, mb;
    logic signed [2*MUL_W-1:0] prod;
    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [3:0] rot_idx;
    logic [2:0] vec_idx;
    logic [2:0] out_idx;
    logic signed [V_W-1:0]   raw_sel;
    logic signed [V_W-1:0]   sub_sel;
    logic signed [V_W-1:0]   diff_v;
    logic signed [V_W-1:0]   vec_v;
    logic signed [V_W+2:0]   term;
    logic [CNT_W:0]          seen_inc;
    logic                    last_mac;
    logic                    out_load;

    ftgc_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(prod));
    ftgc_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    assign rot_idx  = ({2'b0, r_reg} << 1) + {2'b0, r_reg} + {2'b0, c_reg};
    assign vec_idx  = (h_reg ? 3'd3 : 3'd0) + {1'b0, c_reg};
    assign out_idx  = (h_reg ? 3'd3 : 3'd0) + {1'b0, r_reg};
    assign term     = (V_W+3)'(WIDE_W'(prod) >>> ROT_FRAC);
    assign seen_inc = {1'b0, seen_reg} + 1'b1;
    assign last_mac = (c_reg == 2'd2);
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        case (idx_reg)
            3'd0:    raw_sel = in_reg.force_x;
            3'd1:    raw_sel = in_reg.force_y;
            3'd2:    raw_sel = in_reg.force_z;
            3'd3:    raw_sel = in_reg.torque_x;
            3'd4:    raw_sel = in_reg.torque_y;
            default: raw_sel = in_reg.torque_z;
        endcase
        case (idx_reg)
            3'd0, 3'd1, 3'd2: sub_sel = g_reg[idx_reg[1:0]];
            3'd3:             sub_sel = lev_reg[0];
            3'd4:             sub_sel = lev_reg[1];
            default:          sub_sel = '0;
        endcase
    end

    assign diff_v = sat_v(WIDE_W'(raw_sel) - WIDE_W'(sub_sel));
    assign vec_v  = sat_v(WIDE_W'(raw_sel) - WIDE_W'(sub_sel)
                          - WIDE_W'(bias_reg[idx_reg]));

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (state_reg)
            S_GRAV:
            begin
                ma = MUL_W'(rot_reg[4'd6 + {2'b0, idx_reg[1:0]}]);
                mb = MUL_W'($signed({1'b0, weight_reg}));
            end
            S_LEV:
            begin
                ma = idx_reg[0] ? -MUL_W'(g_reg[0]) : MUL_W'(g_reg[1]);
                mb = MUL_W'($signed({1'b0, lever_reg}));
            end
            S_ROT:
            begin
                ma = MUL_W'(rot_reg[rot_idx]);
                mb = MUL_W'(v_reg[vec_idx]);
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid && in_data.action == ACT_SAMPLE)
                    state_next = S_GRAV;
            S_GRAV:
                if (ph_reg && idx_reg == 3'd2)
                    state_next = S_LEV;
            S_LEV:
                if (ph_reg && idx_reg == 3'd1)
                    state_next = S_VEC;
            S_VEC:
                if (idx_reg == 3'd5)
                begin
                    if (!cal_mode_reg)
                        state_next = S_ROT;
                    else if (seen_inc >= {1'b0, calib_reg})
                        state_next = S_DIV;
                    else
                        state_next = S_IDLE;
                end
            S_ROT:
                if (ph_reg && last_mac && r_reg == 2'd2 && h_reg)
                    state_next = S_OUT;
            S_DIV:
                if (ph_reg && div_rsp.done && idx_reg == 3'd5)
                    state_next = S_IDLE;
            S_OUT:
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    assign div_req.start    = (state_reg == S_DIV) && !ph_reg;
    assign div_req.dividend = sum_reg[idx_reg];
    assign div_req.divisor  = seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg    <= WEIGHT_RESET;
            lever_reg     <= LEVER_RESET;
            calib_reg     <= CALIB_RESET;
            for (int i = 0; i < 9; i++)
                rot_reg[i] <= (i % 4 == 0) ? ROT_ONE : '0;
            for (int i = 0; i < 2*AXES; i++)
            begin
                bias_reg[i] <= DEFAULT_BIAS[i];
                sum_reg[i]  <= '0;
            end
            seen_reg      <= '0;
            cal_reg       <= 1'b1;
            cal_mode_reg  <= 1'b0;
            idx_reg       <= '0;
            ph_reg        <= 1'b0;
            r_reg         <= '0;
            c_reg         <= '0;
            h_reg         <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_WEIGHT: weight_reg <= cfg_data[30:0];
                    CFG_LEVER:  lever_reg  <= cfg_data[30:0];
                    CFG_CALIB:  calib_reg  <= cfg_data[15:0];
                    default:    ;
                endcase
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        case (in_data.action)
                            ACT_ROW0, ACT_ROW1, ACT_ROW2:
                            begin
                                rot_reg[{in_data.action, 1'b0} + {2'b0, in_data.action}]
                                    <= in_data.row_x;
                                rot_reg[{in_data.action, 1'b0} + {2'b0, in_data.action} + 4'd1]
                                    <= in_data.row_y;
                                rot_reg[{in_data.action, 1'b0} + {2'b0, in_data.action} + 4'd2]
                                    <= in_data.row_z;
                            end
                            default:
                            begin
                                cal_mode_reg <= cal_reg && (calib_reg != '0);
                                idx_reg      <= '0;
                                ph_reg       <= 1'b0;
                            end
                        endcase
                    end
                S_GRAV:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                        idx_reg <= (idx_reg == 3'd2) ? 3'd0 : idx_reg + 1'b1;
                end
                S_LEV:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                        idx_reg <= (idx_reg == 3'd1) ? 3'd0 : idx_reg + 1'b1;
                end
                S_VEC:
                begin
                    if (cal_mode_reg)
                        sum_reg[idx_reg] <= sat_sum(WIDE_W'(sum_reg[idx_reg])
                                                    + WIDE_W'(diff_v));
                    else
                        v_reg[idx_reg] <= vec_v;
                    if (idx_reg == 3'd5)
                    begin
                        idx_reg <= '0;
                        ph_reg  <= 1'b0;
                        r_reg   <= '0;
                        c_reg   <= '0;
                        h_reg   <= 1'b0;
                        if (cal_mode_reg)
                            seen_reg <= seen_inc[CNT_W-1:0];
                        else
                            cal_reg <= 1'b0;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_ROT:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        if (last_mac)
                        begin
                            c_reg <= '0;
                            r_reg <= (r_reg == 2'd2) ? 2'd0 : r_reg + 1'b1;
                            if (r_reg == 2'd2)
                                h_reg <= !h_reg;
                        end
                        else
                            c_reg <= c_reg + 1'b1;
                    end
                end
                S_DIV:
                begin
                    if (!ph_reg)
                        ph_reg <= 1'b1;
                    else if (div_rsp.done)
                    begin
                        bias_reg[idx_reg] <= sat_v(WIDE_W'(div_rsp.quotient));
                        ph_reg <= 1'b0;
                        if (idx_reg == 3'd5)
                        begin
                            idx_reg <= '0;
                            cal_reg <= 1'b0;
                        end
                        else
                            idx_reg <= idx_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
            in_reg <= in_data;
        if (out_load)
        begin
            for (int i = 0; i < 2*AXES; i++)
                out_reg[i] <= res_reg[i];
        end
        case (state_reg)
            S_GRAV:
                if (ph_reg)
                    g_reg[idx_reg[1:0]] <= sat_v(-WIDE_W'(prod) >>> ROT_FRAC);
            S_LEV:
                if (ph_reg)
                    lev_reg[idx_reg[0]] <= sat_v(WIDE_W'(prod) >>> LEVER_FRAC);
            S_VEC:
                acc_reg <= '0;
            S_ROT:
                if (ph_reg)
                begin
                    if (last_mac)
                    begin
                        res_reg[out_idx] <= sat_v(WIDE_W'(acc_reg + term));
                        acc_reg <= '0;
                    end
                    else
                        acc_reg <= acc_reg + term;
                end
            default: ;
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data.comp_force_x  = out_reg[0];
    assign out_data.comp_force_y  = out_reg[1];
    assign out_data.comp_force_z  = out_reg[2];
    assign out_data.comp_torque_x = out_reg[3];
    assign out_data.comp_torque_y = out_reg[4];
    assign out_data.comp_torque_z = out_reg[5];

endmodule

// ----- design/ftgc_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on ftgc_pkg.
module ftgc_mul
    import ftgc_pkg::*;
(
    input  logic                       clk,
    input  logic signed [MUL_W-1:0]    a,
    input  logic signed [MUL_W-1:0]    b,
    output logic signed [2*MUL_W-1:0]  p
);

    always_ff @(posedge clk)
    begin
        p <= a * b;
    end

endmodule

// ----- design/ftgc_div.sv -----
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on ftgc_pkg.
module ftgc_div
    import ftgc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int DC_W = $clog2(SUM_W);

    logic             busy_reg;
    logic             done_reg;
    logic             neg_reg;
    logic [DC_W-1:0]  cnt_reg;
    logic [SUM_W-1:0] num_reg;
    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W-1:0] den_reg;
    logic [CNT_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, num_reg[SUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DC_W'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg <= req.dividend[SUM_W-1];
            num_reg <= req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : req.dividend;
            rem_reg <= '0;
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? CNT_W'(trial - {1'b0, den_reg}) : trial[CNT_W-1:0];
            num_reg <= {num_reg[SUM_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? -$signed({1'b0, num_reg}) : $signed({1'b0, num_reg});

endmodule

// ----- design/ftgc_checker.sv -----
// Port-level checks for the gravity compensation top level, and their binding.
// Depends on ftgc_pkg and ft_sensor_gravity_compensation.
module ftgc_checker
    import ftgc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input in_word_t   in_data,
    input logic       out_valid,
    input logic       out_ready,
    input out_word_t  out_data,
    input logic       cfg_valid,
    input logic       cfg_ready,
    input logic [1:0] cfg_index,
    input logic [31:0] cfg_data
);

    // A stalled result word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // A sample occupies the sequencer for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.action == ACT_SAMPLE |=> !in_ready)
        else $error("block ready right after a sample");

    // A row load leaves the input ready in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.action != ACT_SAMPLE |=> in_ready)
        else $error("row load stalled the input");

    // A new result appears only from a sample in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result raised while idle");

    // Register writes carry known values and arrive only while the input is ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> in_ready && !$isunknown({cfg_index, cfg_data}))
        else $error("register write while busy or with unknown value");

endmodule

bind ft_sensor_gravity_compensation ftgc_checker u_ftgc_checker (.*);
